[sv/assert_macros.svh]
// assertion macros used by the car arc motion step unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cams_pkg.sv]
// constants, types and tables for the car arc motion step unit
package cams_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANG_SHIFT    = 30 - FRAC_BITS;
    localparam int SCALE_FRAC   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int REDUCE_STEPS = 7;
    localparam int RED_TOP      = REDUCE_STEPS - 1;

    localparam int XY_W    = 32;
    localparam int HD_W    = 19;
    localparam int STEER_W = 2;
    localparam int TIME_W  = 24;
    localparam int SCALE_W = 24;
    localparam int V_W     = TIME_W + 1;
    localparam int NH_W    = 28;
    localparam int Z_W     = 42;
    localparam int A_W     = 34;
    localparam int D_W     = A_W + 2;
    localparam int PR_W    = V_W + A_W;
    localparam int P_W     = 34;
    localparam int M_W     = P_W + SCALE_W + 1;

    // pipeline stage positions
    localparam int ST_IN     = 0;
    localparam int ST_NONNEG = 1;
    localparam int ST_RED0   = 2;
    localparam int ST_FOLD   = ST_RED0 + REDUCE_STEPS;
    localparam int ST_ROT0   = ST_FOLD + 1;
    localparam int ST_PROD   = ST_ROT0 + CORDIC_STEPS;
    localparam int ST_SUM    = ST_PROD + 1;
    localparam int ST_MUL    = ST_SUM + 1;
    localparam int ST_OUT    = ST_MUL + 1;
    localparam int NSTG      = ST_OUT + 1;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 42'sd3373259426;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 42'sd6746518852;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 42'sd1686629713;
    localparam logic signed [NH_W-1:0] PI_F        = 28'sd205887;
    localparam logic signed [NH_W-1:0] TWO_PI_F    = 28'sd411775;
    localparam logic signed [A_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam logic signed [STEER_W-1:0] STEER_LEFT     = 2'sb01;
    localparam logic signed [STEER_W-1:0] STEER_RIGHT    = 2'sb11;
    localparam logic signed [STEER_W-1:0] STEER_STRAIGHT = 2'sb00;
    localparam logic signed [STEER_W-1:0] STEER_SPARE    = 2'sb10;

    localparam logic signed [M_W-1:0] SAT_MAX = 59'sd2147483647;
    localparam logic signed [M_W-1:0] SAT_MIN = -59'sd2147483648;

    typedef struct packed {
        logic signed [XY_W-1:0]    px;
        logic signed [XY_W-1:0]    py;
        logic signed [STEER_W-1:0] steer;
        logic signed [V_W-1:0]     v;
        logic signed [NH_W-1:0]    hd;
    } t_side;

    typedef struct packed {
        logic signed [Z_W-1:0] z0;
        logic signed [Z_W-1:0] z1;
    } t_ang;

    typedef struct packed {
        logic signed [A_W-1:0] x;
        logic signed [A_W-1:0] y;
        logic signed [A_W-1:0] a;
    } t_rot;

    // truncated arctangents of 2^-i in q30
    function automatic logic signed [A_W-1:0] atan_q30(input int idx);
        logic signed [A_W-1:0] r;
        case (idx)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd7;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/car_arc_motion_step_unit.sv]
// Car arc motion step: moves a pose along a unit-radius left arc, right arc or
// straight line, scales the new position and wraps the heading to [-pi, pi].
// A new request is taken every clock cycle while the output is not stalled.
// Each request passes through the 7-stage modulo-2pi angle reduction followed
// by two parallel 30-stage cordic pipelines for the start and end headings. A
// stall on the output freezes the whole pipeline. There is no state between
// requests and no clearing pass after reset; radius_scale resets to 1.0 and
// may be written any time the unit holds no request.
`include "assert_macros.svh"

module car_arc_motion_step_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [cams_pkg::XY_W-1:0]       i_pos_x,
    input  logic signed [cams_pkg::XY_W-1:0]       i_pos_y,
    input  logic signed [cams_pkg::HD_W-1:0]       i_heading,
    input  logic signed [cams_pkg::STEER_W-1:0]    i_steer_dir,
    input  logic                                   i_go_forward,
    input  logic        [cams_pkg::TIME_W-1:0]     i_travel_time,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [cams_pkg::XY_W-1:0]       o_new_x,
    output logic signed [cams_pkg::XY_W-1:0]       o_new_y,
    output logic signed [cams_pkg::HD_W-1:0]       o_new_heading,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [cams_pkg::SCALE_W-1:0]    i_cfg_data
);

    logic                               en;
    logic [cams_pkg::NSTG-1:0]          r_vld;
    logic [cams_pkg::SCALE_W-1:0]       r_scale;

    cams_pkg::t_side r_side [cams_pkg::ST_MUL+1];
    cams_pkg::t_side n_side [cams_pkg::ST_MUL+1];
    cams_pkg::t_ang  r_z    [cams_pkg::ST_NONNEG:cams_pkg::ST_FOLD-1];
    cams_pkg::t_ang  n_z    [cams_pkg::ST_NONNEG:cams_pkg::ST_FOLD-1];

    logic signed [cams_pkg::A_W-1:0]    r_fold_a0, r_fold_a1, n_fold_a0, n_fold_a1;
    logic                               r_fold_n0, r_fold_n1, n_fold_n0, n_fold_n1;

    logic signed [cams_pkg::A_W-1:0]    w_s0, w_c0, w_s1, w_c1;
    logic signed [cams_pkg::D_W-1:0]    r_ds, r_dc;
    logic signed [cams_pkg::PR_W-1:0]   r_pc, r_ps;
    logic signed [cams_pkg::P_W-1:0]    r_sx, r_sy, n_sx, n_sy;
    logic signed [cams_pkg::M_W-1:0]    r_mx, r_my;
    logic signed [cams_pkg::M_W-1:0]    w_rx, w_ry;
    logic signed [cams_pkg::XY_W-1:0]   r_nx, r_ny, n_nx, n_ny;
    logic signed [cams_pkg::HD_W-1:0]   r_nh;
    cams_pkg::t_side                    w_in_side;
    logic                               w_fold_ok, w_hd_ok;

    assign en          = !(r_vld[cams_pkg::ST_OUT] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_in_side.px    = i_pos_x;
        w_in_side.py    = i_pos_y;
        w_in_side.steer = i_steer_dir;
        w_in_side.hd    = cams_pkg::NH_W'(i_heading);
        if (i_go_forward) begin
            w_in_side.v = $signed({1'b0, i_travel_time});
        end else begin
            w_in_side.v = -$signed({1'b0, i_travel_time});
        end
    end

    // end heading, q30 angles and modulo reduction
    always_comb begin
        logic signed [cams_pkg::NH_W-1:0] w_h;
        logic signed [cams_pkg::NH_W-1:0] w_v;
        logic signed [cams_pkg::NH_W-1:0] w_nh;
        logic signed [cams_pkg::NH_W-1:0] w_zh;
        logic signed [cams_pkg::NH_W-1:0] w_mh;
        logic signed [cams_pkg::Z_W-1:0]  w_m;
        logic signed [cams_pkg::Z_W-1:0]  w_a0;
        logic signed [cams_pkg::Z_W-1:0]  w_a1;
        int s;

        for (int i = 1; i <= cams_pkg::ST_MUL; i++) begin
            n_side[i] = r_side[i-1];
        end
        n_side[0] = w_in_side;

        w_h = r_side[cams_pkg::ST_IN].hd;
        w_v = cams_pkg::NH_W'(r_side[cams_pkg::ST_IN].v);
        case (r_side[cams_pkg::ST_IN].steer)
            cams_pkg::STEER_LEFT:  w_nh = w_h + w_v;
            cams_pkg::STEER_RIGHT: w_nh = w_h - w_v;
            default:               w_nh = w_h;
        endcase
        n_z[cams_pkg::ST_NONNEG].z0 =
            (cams_pkg::Z_W'(w_h) <<< cams_pkg::ANG_SHIFT) + cams_pkg::PI_Q30;
        n_z[cams_pkg::ST_NONNEG].z1 =
            (cams_pkg::Z_W'(w_nh) <<< cams_pkg::ANG_SHIFT) + cams_pkg::PI_Q30;
        w_zh = w_nh + cams_pkg::PI_F;

        // lift negative values into range so the reduction below is a plain floor mod
        w_m  = cams_pkg::TWO_PI_Q30 <<< cams_pkg::RED_TOP;
        w_mh = cams_pkg::TWO_PI_F <<< cams_pkg::RED_TOP;
        if (n_z[cams_pkg::ST_NONNEG].z0 < 0) begin
            n_z[cams_pkg::ST_NONNEG].z0 = n_z[cams_pkg::ST_NONNEG].z0 + w_m;
        end
        if (n_z[cams_pkg::ST_NONNEG].z1 < 0) begin
            n_z[cams_pkg::ST_NONNEG].z1 = n_z[cams_pkg::ST_NONNEG].z1 + w_m;
        end
        if (w_zh < 0) begin
            w_zh = w_zh + w_mh;
        end
        n_side[cams_pkg::ST_NONNEG].hd = w_zh;

        // one binary subtract step per stage
        for (int j = 0; j < cams_pkg::REDUCE_STEPS; j++) begin
            s    = cams_pkg::ST_RED0 + j;
            w_m  = cams_pkg::TWO_PI_Q30 <<< (cams_pkg::RED_TOP - j);
            w_mh = cams_pkg::TWO_PI_F <<< (cams_pkg::RED_TOP - j);
            n_z[s] = r_z[s-1];
            if (r_z[s-1].z0 >= w_m) begin
                n_z[s].z0 = r_z[s-1].z0 - w_m;
            end
            if (r_z[s-1].z1 >= w_m) begin
                n_z[s].z1 = r_z[s-1].z1 - w_m;
            end
            if (r_side[s-1].hd >= w_mh) begin
                n_side[s].hd = r_side[s-1].hd - w_mh;
            end
        end

        // recenter to [-pi, pi) and fold into [-pi/2, pi/2]
        w_a0 = r_z[cams_pkg::ST_FOLD-1].z0 - cams_pkg::PI_Q30;
        w_a1 = r_z[cams_pkg::ST_FOLD-1].z1 - cams_pkg::PI_Q30;
        n_side[cams_pkg::ST_FOLD].hd = r_side[cams_pkg::ST_FOLD-1].hd - cams_pkg::PI_F;
        n_fold_n0 = 1'b0;
        n_fold_n1 = 1'b0;
        if (w_a0 > cams_pkg::HALF_PI_Q30) begin
            w_a0      = cams_pkg::PI_Q30 - w_a0;
            n_fold_n0 = 1'b1;
        end else if (w_a0 < -cams_pkg::HALF_PI_Q30) begin
            w_a0      = -cams_pkg::PI_Q30 - w_a0;
            n_fold_n0 = 1'b1;
        end
        if (w_a1 > cams_pkg::HALF_PI_Q30) begin
            w_a1      = cams_pkg::PI_Q30 - w_a1;
            n_fold_n1 = 1'b1;
        end else if (w_a1 < -cams_pkg::HALF_PI_Q30) begin
            w_a1      = -cams_pkg::PI_Q30 - w_a1;
            n_fold_n1 = 1'b1;
        end
        n_fold_a0 = cams_pkg::A_W'(w_a0);
        n_fold_a1 = cams_pkg::A_W'(w_a1);
    end

    cams_cordic u_cordic_start (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_fold_a0),
        .i_neg   (r_fold_n0),
        .o_sin   (w_s0),
        .o_cos   (w_c0)
    );

    cams_cordic u_cordic_end (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_fold_a1),
        .i_neg   (r_fold_n1),
        .o_sin   (w_s1),
        .o_cos   (w_c1)
    );

    // displacement select and position add
    always_comb begin
        logic signed [cams_pkg::D_W-1:0]  w_nds;
        logic signed [cams_pkg::D_W-1:0]  w_ndc;
        logic signed [cams_pkg::P_W-1:0]  w_dx;
        logic signed [cams_pkg::P_W-1:0]  w_dy;
        cams_pkg::t_side                  w_sd;

        w_sd  = r_side[cams_pkg::ST_SUM-1];
        w_nds = -r_ds;
        w_ndc = -r_dc;
        case (w_sd.steer)
            cams_pkg::STEER_LEFT: begin
                w_dx = cams_pkg::P_W'((r_ds + (cams_pkg::D_W'(1) <<< (cams_pkg::ANG_SHIFT - 1)))
                                      >>> cams_pkg::ANG_SHIFT);
                w_dy = cams_pkg::P_W'((r_dc + (cams_pkg::D_W'(1) <<< (cams_pkg::ANG_SHIFT - 1)))
                                      >>> cams_pkg::ANG_SHIFT);
            end
            cams_pkg::STEER_RIGHT: begin
                w_dx = cams_pkg::P_W'((w_nds + (cams_pkg::D_W'(1) <<< (cams_pkg::ANG_SHIFT - 1)))
                                      >>> cams_pkg::ANG_SHIFT);
                w_dy = cams_pkg::P_W'((w_ndc + (cams_pkg::D_W'(1) <<< (cams_pkg::ANG_SHIFT - 1)))
                                      >>> cams_pkg::ANG_SHIFT);
            end
            default: begin
                w_dx = cams_pkg::P_W'((r_pc + (cams_pkg::PR_W'(1) <<< 29)) >>> 30);
                w_dy = cams_pkg::P_W'((r_ps + (cams_pkg::PR_W'(1) <<< 29)) >>> 30);
            end
        endcase
        n_sx = cams_pkg::P_W'(w_sd.px) + w_dx;
        n_sy = cams_pkg::P_W'(w_sd.py) + w_dy;
    end

    // round the scaled product and saturate to 32 bits
    always_comb begin
        w_rx = (r_mx + (cams_pkg::M_W'(1) <<< (cams_pkg::SCALE_FRAC - 1)))
               >>> cams_pkg::SCALE_FRAC;
        w_ry = (r_my + (cams_pkg::M_W'(1) <<< (cams_pkg::SCALE_FRAC - 1)))
               >>> cams_pkg::SCALE_FRAC;
        if (w_rx > cams_pkg::SAT_MAX) begin
            n_nx = cams_pkg::XY_W'(cams_pkg::SAT_MAX);
        end else if (w_rx < cams_pkg::SAT_MIN) begin
            n_nx = cams_pkg::XY_W'(cams_pkg::SAT_MIN);
        end else begin
            n_nx = cams_pkg::XY_W'(w_rx);
        end
        if (w_ry > cams_pkg::SAT_MAX) begin
            n_ny = cams_pkg::XY_W'(cams_pkg::SAT_MAX);
        end else if (w_ry < cams_pkg::SAT_MIN) begin
            n_ny = cams_pkg::XY_W'(cams_pkg::SAT_MIN);
        end else begin
            n_ny = cams_pkg::XY_W'(w_ry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_scale <= cams_pkg::SCALE_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[cams_pkg::NSTG-2:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i <= cams_pkg::ST_MUL; i++) begin
                r_side[i] <= n_side[i];
            end
            for (int i = cams_pkg::ST_NONNEG; i < cams_pkg::ST_FOLD; i++) begin
                r_z[i] <= n_z[i];
            end
            r_fold_a0 <= n_fold_a0;
            r_fold_a1 <= n_fold_a1;
            r_fold_n0 <= n_fold_n0;
            r_fold_n1 <= n_fold_n1;
            r_ds      <= cams_pkg::D_W'(w_s1) - cams_pkg::D_W'(w_s0);
            r_dc      <= cams_pkg::D_W'(w_c0) - cams_pkg::D_W'(w_c1);
            r_pc      <= r_side[cams_pkg::ST_PROD-1].v * w_c0;
            r_ps      <= r_side[cams_pkg::ST_PROD-1].v * w_s0;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_mx      <= r_sx * $signed({1'b0, r_scale});
            r_my      <= r_sy * $signed({1'b0, r_scale});
            r_nx      <= n_nx;
            r_ny      <= n_ny;
            r_nh      <= cams_pkg::HD_W'(r_side[cams_pkg::ST_MUL].hd);
        end
    end

    assign o_out_valid   = r_vld[cams_pkg::ST_OUT];
    assign o_new_x       = r_nx;
    assign o_new_y       = r_ny;
    assign o_new_heading = r_nh;

    assign w_fold_ok = (r_fold_a0 <= cams_pkg::HALF_PI_Q30)
                       && (r_fold_a0 >= -cams_pkg::HALF_PI_Q30);
    // wrapped heading spans -pi to pi inclusive since 2pi rounds up by one lsb
    assign w_hd_ok   = (o_new_heading >= -cams_pkg::PI_F) && (o_new_heading <= cams_pkg::PI_F);

    `ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> (r_vld == '0), "valid bits survive reset")
    `ASSERT_CLK(a_stall_freeze, i_clk, i_rst_n, !en |=> $stable(r_vld), "pipeline moved")
    `ASSERT_CLK(a_fold_range, i_clk, i_rst_n, r_vld[cams_pkg::ST_FOLD] |-> w_fold_ok, "bad fold")
    `ASSERT_CLK(a_heading_wrap, i_clk, i_rst_n, o_out_valid |-> w_hd_ok, "heading not wrapped")

endmodule

[sv/cams_cordic.sv]
// pipelined rotation-mode cordic, one micro-rotation per stage
module cams_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [cams_pkg::A_W-1:0]    i_angle,
    input  logic                               i_neg,
    output logic signed [cams_pkg::A_W-1:0]    o_sin,
    output logic signed [cams_pkg::A_W-1:0]    o_cos
);

    cams_pkg::t_rot r_rot [cams_pkg::CORDIC_STEPS];
    logic           r_neg [cams_pkg::CORDIC_STEPS];

    for (genvar g = 0; g < cams_pkg::CORDIC_STEPS; g++) begin : g_step
        cams_pkg::t_rot w_in;
        cams_pkg::t_rot n_rot;
        logic           w_neg;

        if (g == 0) begin : g_first
            assign w_in  = '{x: cams_pkg::CORDIC_GAIN, y: '0, a: i_angle};
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_in  = r_rot[g-1];
            assign w_neg = r_neg[g-1];
        end

        always_comb begin
            if (!w_in.a[cams_pkg::A_W-1]) begin
                n_rot.x = w_in.x - (w_in.y >>> g);
                n_rot.y = w_in.y + (w_in.x >>> g);
                n_rot.a = w_in.a - cams_pkg::atan_q30(g);
            end else begin
                n_rot.x = w_in.x + (w_in.y >>> g);
                n_rot.y = w_in.y - (w_in.x >>> g);
                n_rot.a = w_in.a + cams_pkg::atan_q30(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rot[g] <= n_rot;
                r_neg[g] <= w_neg;
            end
        end
    end

    assign o_sin = r_rot[cams_pkg::CORDIC_STEPS-1].y;
    assign o_cos = r_neg[cams_pkg::CORDIC_STEPS-1] ? -r_rot[cams_pkg::CORDIC_STEPS-1].x
                                                   : r_rot[cams_pkg::CORDIC_STEPS-1].x;

endmodule
